/* rtl/core/u16550_pkg.sv */
// ----------------------------------------------------------------------------
// u16550_pkg
// shared types, register offsets and constants of the 16550-style uart block
// ----------------------------------------------------------------------------
package u16550_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int IDX_W      = $clog2(FIFO_DEPTH);
   localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W      = LVL_W + 1;

   localparam logic [LVL_W-1:0] DEPTH_LVL = LVL_W'(FIFO_DEPTH);

   // request commands
   typedef enum logic [1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_RX     = 2'd2,
      CMD_TX_POP = 2'd3
   } cmd_type;

   // register offsets
   localparam logic [2:0] REG_DATA = 3'd0;
   localparam logic [2:0] REG_IER  = 3'd1;
   localparam logic [2:0] REG_IIR  = 3'd2;
   localparam logic [2:0] REG_LCR  = 3'd3;
   localparam logic [2:0] REG_MCR  = 3'd4;
   localparam logic [2:0] REG_LSR  = 3'd5;
   localparam logic [2:0] REG_MSR  = 3'd6;
   localparam logic [2:0] REG_SCR  = 3'd7;

   // reset values and fixed patterns
   localparam logic [7:0] LCR_RESET    = 8'h03;
   localparam logic [7:0] DLL_RESET    = 8'h0C;
   localparam logic [7:0] RX_EMPTY_VAL = 8'h60;
   localparam logic [7:0] LSR_BASE     = 8'h60;
   localparam logic [7:0] MSR_FORCE    = 8'hB0;
   localparam logic [7:0] FCR_MASK     = 8'hC1;

   // interrupt id codes
   localparam logic [7:0] IIR_NONE     = 8'h01;
   localparam logic [7:0] IIR_FIFO_ON  = 8'hC0;
   localparam logic [7:0] IIR_RX_DATA  = 8'h04;
   localparam logic [7:0] IIR_RX_TMO   = 8'h0C;
   localparam logic [7:0] IIR_THR      = 8'h02;

   // fcr trigger selections (bits 7:6 and enable bit 0)
   localparam logic [7:0] FCR_TRIG_4   = 8'h41;
   localparam logic [7:0] FCR_TRIG_8   = 8'h81;
   localparam logic [7:0] FCR_TRIG_14  = 8'hC1;

   // circular index: head plus an offset below the depth
   function automatic logic [IDX_W-1:0] wrap_index(input logic [IDX_W-1:0] head,
                                                   input logic [LVL_W-1:0] ofs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(ofs);
      if (sum >= SUM_W'(FIFO_DEPTH)) begin
         sum = sum - SUM_W'(FIFO_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

/* rtl/core/uart_16550_register_model.sv */
// ----------------------------------------------------------------------------
// uart_16550_register_model
// 16550-style uart register block with receive and transmit fifos
// ----------------------------------------------------------------------------
// result path: a request is held in the input register, then handled, and its result
//   is shown from the result register, rsp_valid high for exactly one cycle
// throughput: one request per cycle; busy is never raised, the input register
//   and the result register each hold one request and the receiver cannot stall
// reset (synchronous, active high): fifos empty, lcr = 0x03, divisor = 12,
//   other registers 0; fifo storage is not cleared and is only read once written
// ----------------------------------------------------------------------------
module uart_16550_register_model
   import u16550_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_command,
   input  logic [2:0] req_reg_offset,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_data,
   output logic       rsp_irq_level,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_rx_dropped,
   output logic       rsp_tx_lost
);

   // every cycle is open for a new request
   assign busy = 1'b0;

   // ---------------- input register ----------------
   logic       req_valid_ff;
   cmd_type    cmd_ff;
   logic [2:0] off_ff;
   logic [7:0] wd_ff;
   logic [7:0] rb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      // payload needs no reset
      cmd_ff <= cmd_type'(req_command);
      off_ff <= req_reg_offset;
      wd_ff  <= req_write_data;
      rb_ff  <= req_rx_byte;
   end

   // ---------------- block state ----------------
   logic [7:0]       rx_store [FIFO_DEPTH];
   logic [7:0]       tx_store [FIFO_DEPTH];
   logic [LVL_W-1:0] rx_level_ff, rx_level_in;
   logic [LVL_W-1:0] tx_level_ff, tx_level_in;
   logic [IDX_W-1:0] rx_head_ff, rx_head_in;
   logic [IDX_W-1:0] tx_head_ff, tx_head_in;
   logic             thr_empty_ff, thr_empty_in;
   logic [7:0]       ier_ff, ier_in;
   logic [7:0]       fcr_ff, fcr_in;
   logic [7:0]       lcr_ff, lcr_in;
   logic [7:0]       dll_ff, dll_in;
   logic [7:0]       dlm_ff, dlm_in;
   logic [7:0]       mcr_ff, mcr_in;
   logic [7:0]       msr_ff, msr_in;
   logic [7:0]       scr_ff, scr_in;

   // fifo write ports
   logic             rx_wr_en, tx_wr_en;
   logic [IDX_W-1:0] rx_wr_idx, tx_wr_idx;

   // result next values
   logic [7:0] rd_in;
   logic       irq_in;
   logic       txv_in;
   logic [7:0] txb_in;
   logic       drop_in;
   logic       lost_in;

   logic dlab;
   logic rx_present;
   logic tx_present;
   logic rx_at_trigger;

   assign dlab       = lcr_ff[7];
   assign rx_present = (rx_level_ff != '0);
   assign tx_present = (tx_level_ff != '0);

   // tail positions for pushes
   assign rx_wr_idx = wrap_index(rx_head_ff, rx_level_ff);
   assign tx_wr_idx = wrap_index(tx_head_ff, tx_level_ff);

   // receive trigger level selected by fcr
   always_comb begin
      unique case (fcr_ff & FCR_MASK)
         FCR_TRIG_4:  rx_at_trigger = (rx_level_ff >= LVL_W'(4));
         FCR_TRIG_8:  rx_at_trigger = (rx_level_ff >= LVL_W'(8));
         FCR_TRIG_14: rx_at_trigger = (rx_level_ff >= LVL_W'(14));
         default:     rx_at_trigger = rx_present;
      endcase
   end

   // ---------------- single-pass request handling ----------------
   always_comb begin
      logic [7:0] iid;
      logic [7:0] lsr;

      // hold state unless the request changes it
      rx_level_in  = rx_level_ff;
      tx_level_in  = tx_level_ff;
      rx_head_in   = rx_head_ff;
      tx_head_in   = tx_head_ff;
      thr_empty_in = thr_empty_ff;
      ier_in       = ier_ff;
      fcr_in       = fcr_ff;
      lcr_in       = lcr_ff;
      dll_in       = dll_ff;
      dlm_in       = dlm_ff;
      mcr_in       = mcr_ff;
      msr_in       = msr_ff;
      scr_in       = scr_ff;
      rx_wr_en     = 1'b0;
      tx_wr_en     = 1'b0;
      rd_in        = 8'h00;
      txv_in       = 1'b0;
      txb_in       = 8'h00;
      drop_in      = 1'b0;
      lost_in      = 1'b0;

      // interrupt id as seen before this request
      iid = IIR_NONE | (fcr_ff[0] ? IIR_FIFO_ON : 8'h00);

      // line status: tx empty bits drop as the transmit fifo fills
      lsr = LSR_BASE | {7'd0, rx_present};
      if (tx_present) begin
         lsr[6] = 1'b0;
         if (tx_level_ff >= DEPTH_LVL) begin
            lsr[5] = 1'b0;
         end
      end

      if (req_valid_ff) begin
         unique case (cmd_ff)
            CMD_READ: begin
               unique case (off_ff)
                  REG_DATA: begin
                     if (dlab) begin
                        rd_in = dll_ff;
                     end else if (rx_present) begin
                        // pop the receive fifo
                        rd_in       = rx_store[rx_head_ff];
                        rx_head_in  = wrap_index(rx_head_ff, LVL_W'(1));
                        rx_level_in = rx_level_ff - LVL_W'(1);
                     end else begin
                        rd_in = RX_EMPTY_VAL;
                     end
                  end
                  REG_IER: rd_in = dlab ? dlm_ff : ier_ff;
                  REG_IIR: begin
                     if (ier_ff[0] && rx_present) begin
                        rd_in = (iid & 8'hFE) | (rx_at_trigger ? IIR_RX_DATA : IIR_RX_TMO);
                     end else if (ier_ff[1] && thr_empty_ff) begin
                        // reading the thr-empty id acknowledges it
                        rd_in        = (iid & 8'hFE) | IIR_THR;
                        thr_empty_in = 1'b0;
                     end else begin
                        rd_in = iid;
                     end
                  end
                  REG_LCR: rd_in = lcr_ff;
                  REG_MCR: rd_in = mcr_ff;
                  REG_LSR: rd_in = lsr;
                  REG_MSR: rd_in = msr_ff | MSR_FORCE;
                  REG_SCR: rd_in = scr_ff;
               endcase
            end
            CMD_WRITE: begin
               unique case (off_ff)
                  REG_DATA: begin
                     if (dlab) begin
                        dll_in = wd_ff;
                     end else begin
                        thr_empty_in = 1'b0;
                        if (tx_level_ff < DEPTH_LVL) begin
                           tx_wr_en    = 1'b1;
                           tx_level_in = tx_level_ff + LVL_W'(1);
                        end else begin
                           lost_in = 1'b1;
                        end
                     end
                  end
                  REG_IER: begin
                     if (dlab) begin
                        dlm_in = wd_ff;
                     end else begin
                        ier_in = wd_ff;
                        if (wd_ff[1] && !tx_present) begin
                           thr_empty_in = 1'b1;
                        end
                     end
                  end
                  REG_IIR: begin
                     // fcr write with fifo reset bits
                     fcr_in = wd_ff & FCR_MASK;
                     if (wd_ff[1]) begin
                        rx_level_in = '0;
                        rx_head_in  = '0;
                     end
                     if (wd_ff[2]) begin
                        tx_level_in  = '0;
                        tx_head_in   = '0;
                        thr_empty_in = 1'b1;
                     end
                  end
                  REG_LCR: lcr_in = wd_ff;
                  REG_MCR: mcr_in = wd_ff;
                  REG_LSR: ; // line status is read only
                  REG_MSR: msr_in = wd_ff;
                  REG_SCR: scr_in = wd_ff;
               endcase
            end
            CMD_RX: begin
               if (rx_level_ff < DEPTH_LVL) begin
                  rx_wr_en    = 1'b1;
                  rx_level_in = rx_level_ff + LVL_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
            end
            CMD_TX_POP: begin
               if (tx_present) begin
                  txb_in      = tx_store[tx_head_ff];
                  txv_in      = 1'b1;
                  tx_head_in  = wrap_index(tx_head_ff, LVL_W'(1));
                  tx_level_in = tx_level_ff - LVL_W'(1);
                  // last byte gone: thr empty if enabled
                  if ((tx_level_ff == LVL_W'(1)) && ier_ff[1]) begin
                     thr_empty_in = 1'b1;
                  end
               end
            end
         endcase
      end

      // interrupt line after this request
      irq_in = (ier_in[0] && (rx_level_in != '0)) || (ier_in[1] && thr_empty_in);
   end

   // ---------------- state registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_level_ff  <= '0;
         tx_level_ff  <= '0;
         rx_head_ff   <= '0;
         tx_head_ff   <= '0;
         thr_empty_ff <= 1'b0;
         ier_ff       <= 8'h00;
         fcr_ff       <= 8'h00;
         lcr_ff       <= LCR_RESET;
         dll_ff       <= DLL_RESET;
         dlm_ff       <= 8'h00;
         mcr_ff       <= 8'h00;
         msr_ff       <= 8'h00;
         scr_ff       <= 8'h00;
      end else begin
         rx_level_ff  <= rx_level_in;
         tx_level_ff  <= tx_level_in;
         rx_head_ff   <= rx_head_in;
         tx_head_ff   <= tx_head_in;
         thr_empty_ff <= thr_empty_in;
         ier_ff       <= ier_in;
         fcr_ff       <= fcr_in;
         lcr_ff       <= lcr_in;
         dll_ff       <= dll_in;
         dlm_ff       <= dlm_in;
         mcr_ff       <= mcr_in;
         msr_ff       <= msr_in;
         scr_ff       <= scr_in;
      end
   end

   // fifo storage, no reset: entries are read only after being written
   always_ff @(posedge clock) begin
      if (rx_wr_en && !reset) begin
         rx_store[rx_wr_idx] <= rb_ff;
      end
      if (tx_wr_en && !reset) begin
         tx_store[tx_wr_idx] <= wd_ff;
      end
   end

   // ---------------- result register ----------------
   logic       rsp_valid_ff;
   logic [7:0] rd_ff;
   logic       irq_ff;
   logic       txv_ff;
   logic [7:0] txb_ff;
   logic       drop_ff;
   logic       lost_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      rd_ff   <= rd_in;
      irq_ff  <= irq_in;
      txv_ff  <= txv_in;
      txb_ff  <= txb_in;
      drop_ff <= drop_in;
      lost_ff <= lost_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rd_ff;
   assign rsp_irq_level  = irq_ff;
   assign rsp_tx_valid   = txv_ff;
   assign rsp_tx_byte    = txb_ff;
   assign rsp_rx_dropped = drop_ff;
   assign rsp_tx_lost    = lost_ff;

endmodule

/* rtl/core/u16550_checker.sv */
// ----------------------------------------------------------------------------
// u16550_checker
// port-level checks of the uart register block, bound to the top level
// ----------------------------------------------------------------------------
module u16550_checker
   import u16550_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_command,
   input logic       rsp_valid,
   input logic [7:0] rsp_read_data,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_rx_dropped,
   input logic       rsp_tx_lost
);

   // every result comes from a request taken through the input and result registers
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a request");

   // every request taken out of reset gives a result
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      ($past(start && !busy, 2) && !$past(reset, 1) && !$past(reset, 2)) |-> rsp_valid)
      else $error("request lost");

   // one request causes at most one of pop, drop or loss
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_tx_valid, rsp_rx_dropped, rsp_tx_lost}))
      else $error("conflicting result flags");

   // read data and tx byte are zero unless the request produced them
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_read_data != 8'h00) ||
                     (!rsp_tx_valid && (rsp_tx_byte != 8'h00)))) |->
      ($past(req_command, 2) == CMD_READ))
      else $error("unexpected nonzero result data");

endmodule

bind uart_16550_register_model u16550_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_command    (req_command),
   .rsp_valid      (rsp_valid),
   .rsp_read_data  (rsp_read_data),
   .rsp_tx_valid   (rsp_tx_valid),
   .rsp_tx_byte    (rsp_tx_byte),
   .rsp_rx_dropped (rsp_rx_dropped),
   .rsp_tx_lost    (rsp_tx_lost)
);
